@@ sv/fwl_pkg.sv @@
package fwl_pkg;

   // Fixed field widths of the request and response words
   localparam int REQ_W      = 2;
   localparam int LG_W       = 5;
   localparam int CMD_W      = 3;
   localparam int SECTOR_W   = 5;
   localparam int THR_W      = 16;
   localparam int NUM_LOGICAL = 32;

   // Defaults for the top-level parameters
   localparam int DEF_NUM_BLOCKS = 32;
   localparam int DEF_COUNT_BITS = 16;

   // Wear threshold after reset
   localparam logic [THR_W-1:0] THR_RESET = 16'd5;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ERASE = 2'd2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ERASE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_COPY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NONE  = 3'd4;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_OLD_ERASE,
      ST_SCAN,
      ST_DECIDE,
      ST_MAP_SCAN,
      ST_COLD,
      ST_WRITE_NEW
   } state_type;

   // Control from the sequencer to the minimum scan unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctrl_type;

   // Status of the minimum scan unit
   typedef struct packed {
      logic have_free;
      logic have_used;
   } scan_flags_type;

endpackage

@@ sv/fwl_min_scan.sv @@
module fwl_min_scan #(
   parameter int NUM_BLOCKS = fwl_pkg::DEF_NUM_BLOCKS,
   parameter int COUNT_BITS = fwl_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fwl_pkg::scan_ctrl_type        ctrl,
   input  logic [$clog2(NUM_BLOCKS)-1:0] smp_idx,
   input  logic                          smp_used,
   input  logic [COUNT_BITS-1:0]         smp_count,
   output fwl_pkg::scan_flags_type       flags,
   output logic [$clog2(NUM_BLOCKS)-1:0] free_no,
   output logic [COUNT_BITS-1:0]         free_cnt,
   output logic [$clog2(NUM_BLOCKS)-1:0] used_no,
   output logic [COUNT_BITS-1:0]         used_cnt
);

   localparam int PHYS_W = $clog2(NUM_BLOCKS);

   fwl_pkg::scan_flags_type flags_ff, flags_in;
   logic [PHYS_W-1:0]       free_no_ff, free_no_in;
   logic [COUNT_BITS-1:0]   free_cnt_ff, free_cnt_in;
   logic [PHYS_W-1:0]       used_no_ff, used_no_in;
   logic [COUNT_BITS-1:0]   used_cnt_ff, used_cnt_in;

   // Keep the least-erased block of each kind; strict compare keeps the lowest index on ties
   always_comb begin
      flags_in    = flags_ff;
      free_no_in  = free_no_ff;
      free_cnt_in = free_cnt_ff;
      used_no_in  = used_no_ff;
      used_cnt_in = used_cnt_ff;
      if (ctrl.clear) begin
         flags_in = '0;
      end else if (ctrl.sample) begin
         if (smp_used) begin
            if (!flags_ff.have_used || smp_count < used_cnt_ff) begin
               flags_in.have_used = 1'b1;
               used_no_in         = smp_idx;
               used_cnt_in        = smp_count;
            end
         end else begin
            if (!flags_ff.have_free || smp_count < free_cnt_ff) begin
               flags_in.have_free = 1'b1;
               free_no_in         = smp_idx;
               free_cnt_in        = smp_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      free_no_ff  <= free_no_in;
      free_cnt_ff <= free_cnt_in;
      used_no_ff  <= used_no_in;
      used_cnt_ff <= used_cnt_in;
   end

   assign flags    = flags_ff;
   assign free_no  = free_no_ff;
   assign free_cnt = free_cnt_ff;
   assign used_no  = used_no_ff;
   assign used_cnt = used_cnt_ff;

endmodule

@@ sv/flash_wear_leveling_mapper.sv @@
// Wear-leveling flash translation engine: maps 32 logical blocks onto NUM_BLOCKS physical
// blocks and answers each request with one to four sector command words, the final one
// flagged by rsp_last. Block state (used flag and saturating erase count) sits in a
// single-port synchronous memory, the logical map in a second memory with valid flags in
// flip-flops. One request is worked at a time. A write scans the block memory one entry per
// cycle for the least-erased free and used blocks; when the free block is worn, a reverse
// lookup over the map memory follows. After reset the block memory is swept clear before
// the first request is taken. States that emit a response word wait while it stalls.
module flash_wear_leveling_mapper #(
   parameter int NUM_BLOCKS = fwl_pkg::DEF_NUM_BLOCKS,
   parameter int COUNT_BITS = fwl_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fwl_pkg::REQ_W-1:0]     req_type,
   input  logic [fwl_pkg::LG_W-1:0]      req_logical_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fwl_pkg::CMD_W-1:0]     rsp_command,
   output logic [fwl_pkg::SECTOR_W-1:0]  rsp_phys_sector,
   output logic [fwl_pkg::SECTOR_W-1:0]  rsp_copy_source,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [fwl_pkg::THR_W-1:0]     csr_wr_data
);

   localparam int PHYS_W = $clog2(NUM_BLOCKS);
   localparam int BIDX_W = $clog2(NUM_BLOCKS + 1);
   localparam int MIDX_W = fwl_pkg::LG_W + 1;
   localparam int CMP_W  = (COUNT_BITS > fwl_pkg::THR_W) ? COUNT_BITS : fwl_pkg::THR_W;

   // State and latched request
   fwl_pkg::state_type              state_ff, state_in;
   logic [fwl_pkg::REQ_W-1:0]       type_ff;
   logic [fwl_pkg::LG_W-1:0]        lg_ff;
   logic [PHYS_W-1:0]               old_phys_ff;
   logic [fwl_pkg::LG_W-1:0]        owner_ff;
   logic [fwl_pkg::THR_W-1:0]       thr_ff;

   // Scan counters and read-pending flags
   logic [BIDX_W-1:0]               blk_idx_ff, blk_idx_in;
   logic [MIDX_W-1:0]               map_idx_ff, map_idx_in;
   logic                            bpend_ff;
   logic [PHYS_W-1:0]               bpend_idx_ff;
   logic                            mpend_ff;
   logic [fwl_pkg::LG_W-1:0]        mpend_idx_ff;

   // Memories
   logic [COUNT_BITS:0]             blk_mem [NUM_BLOCKS];
   logic [COUNT_BITS:0]             blk_rd_data_ff;
   logic [PHYS_W-1:0]               map_mem [fwl_pkg::NUM_LOGICAL];
   logic [PHYS_W-1:0]               map_rd_data_ff;
   logic [fwl_pkg::NUM_LOGICAL-1:0] map_valid_ff;

   logic                            blk_rd_en, blk_wr_en;
   logic [PHYS_W-1:0]               blk_rd_addr, blk_wr_addr;
   logic [COUNT_BITS:0]             blk_wr_data;
   logic                            map_rd_en, map_wr_en;
   logic [fwl_pkg::LG_W-1:0]        map_rd_addr, map_wr_addr;
   logic [PHYS_W-1:0]               map_wr_data;
   logic                            map_set, map_clr;

   // Response register
   logic                            rsp_valid_ff;
   logic [fwl_pkg::CMD_W-1:0]       rsp_command_ff;
   logic [fwl_pkg::SECTOR_W-1:0]    rsp_phys_ff;
   logic [fwl_pkg::SECTOR_W-1:0]    rsp_src_ff;
   logic                            rsp_last_ff;

   logic                            emit_req, emit_last, emit_fire, slot_free;
   logic [fwl_pkg::CMD_W-1:0]       emit_cmd;
   logic [PHYS_W-1:0]               emit_phys, emit_src;

   // Scan unit
   fwl_pkg::scan_ctrl_type          scan_ctrl;
   fwl_pkg::scan_flags_type         scan_flags;
   logic [PHYS_W-1:0]               free_no, used_no;
   logic [COUNT_BITS-1:0]           free_cnt, used_cnt;

   logic                            lk_valid, owner_hit, migrate, blk_issue, map_issue;
   logic [COUNT_BITS-1:0]           rd_cnt, rd_cnt_inc, used_cnt_inc;

   fwl_min_scan #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .COUNT_BITS(COUNT_BITS)
   ) u_min_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .smp_idx   (bpend_idx_ff),
      .smp_used  (blk_rd_data_ff[COUNT_BITS]),
      .smp_count (blk_rd_data_ff[COUNT_BITS-1:0]),
      .flags     (scan_flags),
      .free_no   (free_no),
      .free_cnt  (free_cnt),
      .used_no   (used_no),
      .used_cnt  (used_cnt)
   );

   // Decode helpers
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign emit_fire    = emit_req && slot_free;
   assign lk_valid     = map_valid_ff[lg_ff];
   assign owner_hit    = mpend_ff && map_valid_ff[mpend_idx_ff] && (map_rd_data_ff == used_no);
   assign migrate      = (CMP_W'(free_cnt) >= CMP_W'(thr_ff)) && scan_flags.have_used;
   assign rd_cnt       = blk_rd_data_ff[COUNT_BITS-1:0];
   assign rd_cnt_inc   = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
   assign used_cnt_inc = (used_cnt == {COUNT_BITS{1'b1}}) ? used_cnt
                                                          : used_cnt + COUNT_BITS'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwl_pkg::ST_CLEAR: begin
            if (blk_idx_ff == BIDX_W'(NUM_BLOCKS - 1)) state_in = fwl_pkg::ST_IDLE;
         end
         fwl_pkg::ST_IDLE: begin
            if (req_valid) state_in = fwl_pkg::ST_LOOKUP;
         end
         fwl_pkg::ST_LOOKUP: begin
            case (type_ff)
               fwl_pkg::REQ_WRITE: begin
                  state_in = lk_valid ? fwl_pkg::ST_OLD_ERASE : fwl_pkg::ST_SCAN;
               end
               fwl_pkg::REQ_ERASE: begin
                  if (lk_valid) state_in = fwl_pkg::ST_OLD_ERASE;
                  else if (slot_free) state_in = fwl_pkg::ST_IDLE;
               end
               default: begin
                  if (slot_free) state_in = fwl_pkg::ST_IDLE;
               end
            endcase
         end
         fwl_pkg::ST_OLD_ERASE: begin
            if (slot_free) begin
               state_in = (type_ff == fwl_pkg::REQ_ERASE) ? fwl_pkg::ST_IDLE : fwl_pkg::ST_SCAN;
            end
         end
         fwl_pkg::ST_SCAN: begin
            // Last entry is sampled at this edge, so the flags are final in the next state
            if (!blk_issue) state_in = fwl_pkg::ST_DECIDE;
         end
         fwl_pkg::ST_DECIDE: begin
            if (slot_free) begin
               if (scan_flags.have_free && migrate) state_in = fwl_pkg::ST_MAP_SCAN;
               else state_in = fwl_pkg::ST_IDLE;
            end
         end
         fwl_pkg::ST_MAP_SCAN: begin
            if (owner_hit) state_in = fwl_pkg::ST_COLD;
            else if (!map_issue) state_in = fwl_pkg::ST_WRITE_NEW;
         end
         fwl_pkg::ST_COLD: begin
            if (slot_free) state_in = fwl_pkg::ST_WRITE_NEW;
         end
         fwl_pkg::ST_WRITE_NEW: begin
            if (slot_free) state_in = fwl_pkg::ST_IDLE;
         end
         default: state_in = fwl_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory ports, scan control and response words
   always_comb begin
      req_ready         = 1'b0;
      blk_rd_en         = 1'b0;
      blk_rd_addr       = '0;
      blk_wr_en         = 1'b0;
      blk_wr_addr       = '0;
      blk_wr_data       = '0;
      map_rd_en         = 1'b0;
      map_rd_addr       = '0;
      map_wr_en         = 1'b0;
      map_wr_addr       = '0;
      map_wr_data       = '0;
      map_set           = 1'b0;
      map_clr           = 1'b0;
      blk_issue         = 1'b0;
      map_issue         = 1'b0;
      emit_req          = 1'b0;
      emit_cmd          = fwl_pkg::CMD_NONE;
      emit_phys         = '0;
      emit_src          = '0;
      emit_last         = 1'b0;
      scan_ctrl.clear   = 1'b0;
      scan_ctrl.sample  = bpend_ff;
      unique case (state_ff)
         fwl_pkg::ST_CLEAR: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = blk_idx_ff[PHYS_W-1:0];
         end
         fwl_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            map_rd_en       = req_valid;
            map_rd_addr     = req_logical_index;
            scan_ctrl.clear = 1'b1;
         end
         fwl_pkg::ST_LOOKUP: begin
            case (type_ff) inside
               fwl_pkg::REQ_READ: begin
                  emit_req  = 1'b1;
                  emit_last = 1'b1;
                  if (lk_valid) begin
                     emit_cmd  = fwl_pkg::CMD_READ;
                     emit_phys = map_rd_data_ff;
                  end
               end
               fwl_pkg::REQ_WRITE, fwl_pkg::REQ_ERASE: begin
                  if (lk_valid) begin
                     blk_rd_en   = 1'b1;
                     blk_rd_addr = map_rd_data_ff;
                     map_clr     = 1'b1;
                  end else if (type_ff == fwl_pkg::REQ_ERASE) begin
                     emit_req  = 1'b1;
                     emit_last = 1'b1;
                  end
               end
               default: begin
                  emit_req  = 1'b1;
                  emit_last = 1'b1;
               end
            endcase
         end
         fwl_pkg::ST_OLD_ERASE: begin
            emit_req    = 1'b1;
            emit_cmd    = fwl_pkg::CMD_ERASE;
            emit_phys   = old_phys_ff;
            emit_last   = (type_ff == fwl_pkg::REQ_ERASE);
            blk_wr_en   = slot_free;
            blk_wr_addr = old_phys_ff;
            blk_wr_data = {1'b0, rd_cnt_inc};
         end
         fwl_pkg::ST_SCAN: begin
            blk_issue   = (blk_idx_ff < BIDX_W'(NUM_BLOCKS));
            blk_rd_en   = blk_issue;
            blk_rd_addr = blk_idx_ff[PHYS_W-1:0];
         end
         fwl_pkg::ST_DECIDE: begin
            emit_req = 1'b1;
            if (!scan_flags.have_free) begin
               emit_last = 1'b1;
            end else begin
               blk_wr_en   = slot_free;
               blk_wr_addr = free_no;
               blk_wr_data = {1'b1, free_cnt};
               emit_phys   = free_no;
               if (migrate) begin
                  emit_cmd = fwl_pkg::CMD_COPY;
                  emit_src = used_no;
               end else begin
                  emit_cmd    = fwl_pkg::CMD_WRITE;
                  emit_last   = 1'b1;
                  map_wr_en   = slot_free;
                  map_wr_addr = lg_ff;
                  map_wr_data = free_no;
                  map_set     = slot_free;
               end
            end
         end
         fwl_pkg::ST_MAP_SCAN: begin
            map_issue   = (map_idx_ff < MIDX_W'(fwl_pkg::NUM_LOGICAL)) && !owner_hit;
            map_rd_en   = map_issue;
            map_rd_addr = map_idx_ff[fwl_pkg::LG_W-1:0];
         end
         fwl_pkg::ST_COLD: begin
            // Erase the cold block, move its owner to the worn block, then reuse it
            emit_req    = 1'b1;
            emit_cmd    = fwl_pkg::CMD_ERASE;
            emit_phys   = used_no;
            blk_wr_en   = slot_free;
            blk_wr_addr = used_no;
            blk_wr_data = {1'b1, used_cnt_inc};
            map_wr_en   = slot_free;
            map_wr_addr = owner_ff;
            map_wr_data = free_no;
         end
         fwl_pkg::ST_WRITE_NEW: begin
            emit_req    = 1'b1;
            emit_cmd    = fwl_pkg::CMD_WRITE;
            emit_phys   = used_no;
            emit_last   = 1'b1;
            map_wr_en   = slot_free;
            map_wr_addr = lg_ff;
            map_wr_data = used_no;
            map_set     = slot_free;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   // Advance scan counters; they rest at zero outside their sweeps
   assign blk_idx_in = (state_ff == fwl_pkg::ST_CLEAR || blk_issue) ?
                       blk_idx_ff + BIDX_W'(1) : '0;
   assign map_idx_in = map_issue ? map_idx_ff + MIDX_W'(1) : '0;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwl_pkg::ST_CLEAR;
         blk_idx_ff   <= '0;
         map_idx_ff   <= '0;
         bpend_ff     <= 1'b0;
         mpend_ff     <= 1'b0;
         map_valid_ff <= '0;
         thr_ff       <= fwl_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         blk_idx_ff <= blk_idx_in;
         map_idx_ff <= map_idx_in;
         bpend_ff   <= blk_issue;
         mpend_ff   <= map_issue;
         if (map_set) map_valid_ff[lg_ff] <= 1'b1;
         if (map_clr) map_valid_ff[lg_ff] <= 1'b0;
         if (csr_wr_en) thr_ff <= csr_wr_data;
         if (emit_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff <= req_type;
         lg_ff   <= req_logical_index;
      end
      if (state_ff == fwl_pkg::ST_LOOKUP) old_phys_ff <= map_rd_data_ff;
      if (owner_hit) owner_ff <= mpend_idx_ff;
      bpend_idx_ff <= blk_idx_ff[PHYS_W-1:0];
      mpend_idx_ff <= map_idx_ff[fwl_pkg::LG_W-1:0];
      if (emit_fire) begin
         rsp_command_ff <= emit_cmd;
         rsp_phys_ff    <= fwl_pkg::SECTOR_W'(emit_phys);
         rsp_src_ff     <= fwl_pkg::SECTOR_W'(emit_src);
         rsp_last_ff    <= emit_last;
      end
   end

   // Block memory; the sequencer never reads and writes it in the same cycle
   always_ff @(posedge clock) begin
      if (blk_wr_en) blk_mem[blk_wr_addr] <= blk_wr_data;
      if (blk_rd_en) blk_rd_data_ff <= blk_mem[blk_rd_addr];
   end

   // Map memory; entries are gated by the valid flags
   always_ff @(posedge clock) begin
      if (map_wr_en) map_mem[map_wr_addr] <= map_wr_data;
      if (map_rd_en) map_rd_data_ff <= map_mem[map_rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_phys_sector = rsp_phys_ff;
   assign rsp_copy_source = rsp_src_ff;
   assign rsp_last        = rsp_last_ff;

   // Checks
   a_none_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == fwl_pkg::CMD_NONE |-> rsp_last && rsp_phys_sector == '0)
      else $error("not-mapped word must be final and carry block zero");

   a_copy_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == fwl_pkg::CMD_COPY |-> !rsp_last)
      else $error("copy word flagged as final");

   a_blk_port: assert property (@(posedge clock) disable iff (reset)
      !(blk_wr_en && blk_rd_en))
      else $error("block memory read and write in one cycle");

   a_map_port: assert property (@(posedge clock) disable iff (reset)
      !(map_wr_en && map_rd_en))
      else $error("map memory read and write in one cycle");

endmodule
